@@ hw/rtl/stl_pkg.sv @@
// Shared types, codes and character-class helpers of the script token lexer.
`timescale 1ns / 1ps

package stl_pkg;

  // Default number of word bytes held for keyword matching
  localparam int KEYWORD_BYTES_DEF = 8;

  // Depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Results one input item can cause at most
  localparam int MAX_RESULTS = 3;

  // Result kinds
  localparam logic [1:0] KIND_VALUE = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Token types
  localparam logic [2:0] TT_NUMBER   = 3'd0;
  localparam logic [2:0] TT_IDENT    = 3'd1;
  localparam logic [2:0] TT_KEYWORD  = 3'd2;
  localparam logic [2:0] TT_STRING   = 3'd3;
  localparam logic [2:0] TT_DOT      = 3'd4;
  localparam logic [2:0] TT_OPERATOR = 3'd5;
  localparam logic [2:0] TT_EOF      = 3'd6;

  // Keyword text, first character in the top byte, padded with spaces
  localparam int KW_COUNT = 9;
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    "let     ", "const   ", "var     ", "function",
    "return  ", "if      ", "else    ", "while   ", "for     "
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd5, 4'd3, 4'd8, 4'd6, 4'd2, 4'd4, 4'd5, 4'd3
  };

  // Lexer modes
  typedef enum logic [6:0] {
    MODE_IDLE     = 7'b0000001,
    MODE_NUMBER   = 7'b0000010,
    MODE_WORD     = 7'b0000100,
    MODE_STRING   = 7'b0001000,
    MODE_ESCAPE   = 7'b0010000,
    MODE_OPERATOR = 7'b0100000,
    MODE_ERROR    = 7'b1000000
  } lex_mode_t;

  // One result item
  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] ttype;
    logic [7:0] value;
  } res_t;

  // Results caused by one input item
  typedef struct packed {
    logic [1:0]                   cnt;
    res_t [MAX_RESULTS-1:0]       res;
  } cmd_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic                full;
    logic                empty;
    logic [QUEUE_AW:0]   count;
  } q_stat_t;

  function automatic res_t mk_res(logic [1:0] kind, logic [2:0] ttype, logic [7:0] value);
    res_t r;
    r.kind  = kind;
    r.ttype = ttype;
    r.value = value;
    return r;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'd32) || (c inside {[8'd9:8'd13]});
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"]};
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == "_");
  endfunction

  function automatic logic is_op(logic [7:0] c);
    return c inside {"+", "-", "*", "/", "(", ")", "=", ";", "{", "}",
                     "[", "]", ",", "<", ">", "!", "&", "|"};
  endfunction

  // Two-character operators
  function automatic logic pairs(logic [7:0] first, logic [7:0] second);
    logic p;
    p = 1'b0;
    if (second == "=") begin
      p = first inside {"=", "!", "<", ">"};
    end else if (second == "&") begin
      p = (first == "&");
    end else if (second == "|") begin
      p = (first == "|");
    end
    return p;
  endfunction

endpackage

@@ hw/rtl/stl_front.sv @@
// Front of the lexer: accepts source bytes, steps the lexer state, builds result commands.
`timescale 1ns / 1ps

module stl_front #(
  parameter int KEYWORD_BYTES = stl_pkg::KEYWORD_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] ch
  input  logic             in_tlast,   // end_of_input
  input  stl_pkg::q_stat_t q_stat,
  output logic             q_push,
  output stl_pkg::cmd_t    q_cmd
);

  localparam int IW = (KEYWORD_BYTES > 1) ? $clog2(KEYWORD_BYTES) : 1;
  localparam int LW = $clog2(KEYWORD_BYTES + 2);

  stl_pkg::lex_mode_t mode_r, mode_nxt;
  logic               seen_dot_r, seen_dot_nxt;
  logic               quote_r, quote_nxt;
  logic [7:0]         pend_r, pend_nxt;
  logic [LW-1:0]      len_r, len_nxt;
  logic [7:0]         word_r   [KEYWORD_BYTES];
  logic [7:0]         word_nxt [KEYWORD_BYTES];

  logic               accept;
  logic               kw_hit;
  logic [2:0]         word_type;
  stl_pkg::cmd_t      cmd;
  logic [7:0]         c;

  assign c         = in_tdata;
  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;

  // Match the held word against the keyword table
  always_comb begin
    logic m;
    kw_hit = 1'b0;
    for (int k = 0; k < stl_pkg::KW_COUNT; k++) begin
      m = (len_r == LW'(stl_pkg::KW_LEN[k]));
      for (int i = 0; i < 8; i++) begin
        if (i < int'(stl_pkg::KW_LEN[k])) begin
          m = m && (word_r[i] == stl_pkg::KW_TEXT[k][63-8*i -: 8]);
        end
      end
      kw_hit = kw_hit || m;
    end
    word_type = kw_hit ? stl_pkg::TT_KEYWORD : stl_pkg::TT_IDENT;
  end

  // Step the lexer for one item and collect its results
  always_comb begin
    logic       restart;
    logic [1:0] n;
    logic [7:0] close_q;
    mode_nxt     = mode_r;
    seen_dot_nxt = seen_dot_r;
    quote_nxt    = quote_r;
    pend_nxt     = pend_r;
    len_nxt      = len_r;
    word_nxt     = word_r;
    cmd          = '0;
    restart      = 1'b0;
    n            = 2'd0;
    close_q      = quote_r ? 8'h27 : 8'h22;

    if (in_tlast) begin
      // Close any open token, then end of file, then clear state
      case (mode_r)
        stl_pkg::MODE_NUMBER: begin
          cmd.res[n] = stl_pkg::mk_res(stl_pkg::KIND_END, stl_pkg::TT_NUMBER, 8'd0);
          n = n + 2'd1;
        end
        stl_pkg::MODE_WORD: begin
          cmd.res[n] = stl_pkg::mk_res(stl_pkg::KIND_END, word_type, 8'd0);
          n = n + 2'd1;
        end
        stl_pkg::MODE_STRING, stl_pkg::MODE_ESCAPE: begin
          cmd.res[n] = stl_pkg::mk_res(stl_pkg::KIND_END, stl_pkg::TT_STRING, 8'd0);
          n = n + 2'd1;
        end
        stl_pkg::MODE_OPERATOR: begin
          cmd.res[n] = stl_pkg::mk_res(stl_pkg::KIND_END, stl_pkg::TT_OPERATOR, 8'd0);
          n = n + 2'd1;
        end
        default: ;
      endcase
      cmd.res[n] = stl_pkg::mk_res(stl_pkg::KIND_END, stl_pkg::TT_EOF, 8'd0);
      n = n + 2'd1;
      mode_nxt     = stl_pkg::MODE_IDLE;
      seen_dot_nxt = 1'b0;
      quote_nxt    = 1'b0;
      pend_nxt     = 8'd0;
      len_nxt      = '0;
    end else begin
      case (mode_r)
        stl_pkg::MODE_NUMBER: begin
          if (stl_pkg::is_digit(c)) begin
            cmd.res[n] = stl_pkg::mk_res(stl_pkg::KIND_VALUE, stl_pkg::TT_NUMBER, c);
            n = n + 2'd1;
          end else if (c == "." && !seen_dot_r) begin
            seen_dot_nxt = 1'b1;
            cmd.res[n] = stl_pkg::mk_res(stl_pkg::KIND_VALUE, stl_pkg::TT_NUMBER, c);
            n = n + 2'd1;
          end else begin
            cmd.res[n] = stl_pkg::mk_res(stl_pkg::KIND_END, stl_pkg::TT_NUMBER, 8'd0);
            n = n + 2'd1;
            restart = 1'b1;
          end
        end
        stl_pkg::MODE_WORD: begin
          if (stl_pkg::is_word(c)) begin
            if (len_r < LW'(KEYWORD_BYTES)) begin
              word_nxt[len_r[IW-1:0]] = c;
            end
            if (len_r <= LW'(KEYWORD_BYTES)) begin
              len_nxt = len_r + LW'(1);
            end
            cmd.res[n] = stl_pkg::mk_res(stl_pkg::KIND_VALUE, stl_pkg::TT_IDENT, c);
            n = n + 2'd1;
          end else begin
            cmd.res[n] = stl_pkg::mk_res(stl_pkg::KIND_END, word_type, 8'd0);
            n = n + 2'd1;
            restart = 1'b1;
          end
        end
        stl_pkg::MODE_STRING: begin
          if (c == close_q) begin
            cmd.res[n] = stl_pkg::mk_res(stl_pkg::KIND_END, stl_pkg::TT_STRING, 8'd0);
            n = n + 2'd1;
            mode_nxt = stl_pkg::MODE_IDLE;
          end else if (c == "\\") begin
            mode_nxt = stl_pkg::MODE_ESCAPE;
          end else begin
            cmd.res[n] = stl_pkg::mk_res(stl_pkg::KIND_VALUE, stl_pkg::TT_STRING, c);
            n = n + 2'd1;
          end
        end
        stl_pkg::MODE_ESCAPE: begin
          case (c)
            "n":     cmd.res[n] = stl_pkg::mk_res(stl_pkg::KIND_VALUE, stl_pkg::TT_STRING, 8'd10);
            "t":     cmd.res[n] = stl_pkg::mk_res(stl_pkg::KIND_VALUE, stl_pkg::TT_STRING, 8'd9);
            "r":     cmd.res[n] = stl_pkg::mk_res(stl_pkg::KIND_VALUE, stl_pkg::TT_STRING, 8'd13);
            default: cmd.res[n] = stl_pkg::mk_res(stl_pkg::KIND_VALUE, stl_pkg::TT_STRING, c);
          endcase
          n = n + 2'd1;
          mode_nxt = stl_pkg::MODE_STRING;
        end
        stl_pkg::MODE_OPERATOR: begin
          pend_nxt = 8'd0;
          if (stl_pkg::pairs(pend_r, c)) begin
            cmd.res[n] = stl_pkg::mk_res(stl_pkg::KIND_VALUE, stl_pkg::TT_OPERATOR, c);
            n = n + 2'd1;
            cmd.res[n] = stl_pkg::mk_res(stl_pkg::KIND_END, stl_pkg::TT_OPERATOR, 8'd0);
            n = n + 2'd1;
            mode_nxt = stl_pkg::MODE_IDLE;
          end else begin
            cmd.res[n] = stl_pkg::mk_res(stl_pkg::KIND_END, stl_pkg::TT_OPERATOR, 8'd0);
            n = n + 2'd1;
            restart = 1'b1;
          end
        end
        stl_pkg::MODE_ERROR: ;
        default: restart = 1'b1;
      endcase

      // Start a new token on this byte
      if (restart) begin
        mode_nxt = stl_pkg::MODE_IDLE;
        if (stl_pkg::is_space(c)) begin
          mode_nxt = stl_pkg::MODE_IDLE;
        end else if (stl_pkg::is_digit(c)) begin
          mode_nxt     = stl_pkg::MODE_NUMBER;
          seen_dot_nxt = 1'b0;
          cmd.res[n] = stl_pkg::mk_res(stl_pkg::KIND_VALUE, stl_pkg::TT_NUMBER, c);
          n = n + 2'd1;
        end else if (stl_pkg::is_alpha(c) || c == "_") begin
          mode_nxt    = stl_pkg::MODE_WORD;
          word_nxt[0] = c;
          len_nxt     = LW'(1);
          cmd.res[n] = stl_pkg::mk_res(stl_pkg::KIND_VALUE, stl_pkg::TT_IDENT, c);
          n = n + 2'd1;
        end else if (c == 8'h22 || c == 8'h27) begin
          mode_nxt  = stl_pkg::MODE_STRING;
          quote_nxt = (c == 8'h27);
        end else if (c == ".") begin
          cmd.res[n] = stl_pkg::mk_res(stl_pkg::KIND_VALUE, stl_pkg::TT_DOT, c);
          n = n + 2'd1;
          cmd.res[n] = stl_pkg::mk_res(stl_pkg::KIND_END, stl_pkg::TT_DOT, 8'd0);
          n = n + 2'd1;
        end else if (stl_pkg::is_op(c)) begin
          mode_nxt = stl_pkg::MODE_OPERATOR;
          pend_nxt = c;
          cmd.res[n] = stl_pkg::mk_res(stl_pkg::KIND_VALUE, stl_pkg::TT_OPERATOR, c);
          n = n + 2'd1;
        end else begin
          mode_nxt = stl_pkg::MODE_ERROR;
          cmd.res[n] = stl_pkg::mk_res(stl_pkg::KIND_ERROR, stl_pkg::TT_NUMBER, c);
          n = n + 2'd1;
        end
      end
    end
    cmd.cnt = n;
  end

  assign q_push = accept && (cmd.cnt != 2'd0);
  assign q_cmd  = cmd;

  // Lexer control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= stl_pkg::MODE_IDLE;
      seen_dot_r <= 1'b0;
      quote_r    <= 1'b0;
      pend_r     <= 8'd0;
      len_r      <= '0;
    end else if (accept) begin
      mode_r     <= mode_nxt;
      seen_dot_r <= seen_dot_nxt;
      quote_r    <= quote_nxt;
      pend_r     <= pend_nxt;
      len_r      <= len_nxt;
    end
  end

  // Held word bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      word_r <= word_nxt;
    end
  end

endmodule

@@ hw/rtl/stl_queue.sv @@
// Command queue between lexer front and result back.
`timescale 1ns / 1ps

module stl_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  stl_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output stl_pkg::cmd_t    head_cmd,
  output stl_pkg::q_stat_t stat
);

  localparam int AW = stl_pkg::QUEUE_AW;

  stl_pkg::cmd_t    mem_r [stl_pkg::QUEUE_DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;

  assign stat.full  = (count_r == (AW+1)'(stl_pkg::QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;
  assign head_cmd   = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + AW'(1) : rd_ptr_r;
    count_nxt  = count_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store command
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ hw/rtl/stl_back.sv @@
// Result back end: walks each queued command and drives the result channel register.
`timescale 1ns / 1ps

module stl_back (
  input  logic             clk,
  input  logic             rst_n,
  input  stl_pkg::cmd_t    head_cmd,
  input  stl_pkg::q_stat_t q_stat,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [15:0]      out_tdata,  // [1:0] result_kind, [4:2] token_type, [12:5] value_byte
  output logic             out_tlast   // last_result
);

  logic [1:0]    idx_r, idx_nxt;
  logic          valid_r, valid_nxt;
  stl_pkg::res_t res_r;
  logic          last_r;
  logic          load;
  logic          at_last;
  stl_pkg::res_t cur;

  assign load    = !q_stat.empty && (!valid_r || out_tready);
  assign cur     = head_cmd.res[idx_r];
  assign at_last = (idx_r == head_cmd.cnt - 2'd1);
  assign pop     = load && at_last;

  // Step through the results of the head command
  always_comb begin
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = at_last ? 2'd0 : idx_r + 2'd1;
    end
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= cur;
      last_r <= at_last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {3'd0, res_r.value, res_r.ttype, res_r.kind};
  assign out_tlast  = last_r;

endmodule

@@ hw/rtl/script_token_lexer.sv @@
// Top level of the script token lexer: front, command queue and result back end.
`timescale 1ns / 1ps
// Streaming lexer for a small scripting-language subset.
// Input channel in_*: one source byte per item in in_tdata[7:0]; in_tlast high
// marks end of input (the byte is then ignored), which closes any open token
// and emits an end-of-file token.
// Result channel out_*: one result per item; tdata packs kind, token type and
// value byte; out_tlast marks the last result caused by one input byte.
// A byte's results pass through the command queue and then the single result
// register before they are valid on the result channel.
// Throughput: the front takes one byte per cycle while the four-entry command
// queue has room; the back delivers one result per cycle while results are
// queued and the receiver is ready; a byte causes at most three results.
// Reset (synchronous, active low) returns the lexer to idle and empties the
// queue. When the receiver stalls, the result is held, the queue fills and
// in_tready drops once it is full.
module script_token_lexer #(
  parameter int KEYWORD_BYTES = stl_pkg::KEYWORD_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,   // end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [1:0] result_kind, [4:2] token_type, [12:5] value_byte
  output logic        out_tlast   // last_result
);

  stl_pkg::q_stat_t q_stat;
  stl_pkg::cmd_t    push_cmd;
  stl_pkg::cmd_t    head_cmd;
  logic             q_push;
  logic             q_pop;

  stl_front #(
    .KEYWORD_BYTES(KEYWORD_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  stl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  stl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_cmd   (head_cmd),
    .q_stat     (q_stat),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  // End of input always produces at least the end-of-file result
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |-> q_push)
    else $error("end of input pushed no command");

  // Never pop an empty queue
  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // Occupancy rises by one on a push without a pop
  assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !q_pop) |=> (q_stat.count == $past(q_stat.count) + 1'b1))
    else $error("queue count did not advance on push");
`endif

endmodule

@@ tb/sv/script_token_lexer_tb.sv @@
// Self-checking testbench of the script token lexer: directed sources and random programs.
`timescale 1ns / 1ps

module script_token_lexer_tb;

  localparam int          CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_ITEMS = 360;
  localparam int unsigned DRAIN_CYCLES = 20;

  // Keyword text, right-aligned and zero-padded so that a word matches by value alone
  localparam logic [63:0] KEYWORD_WORDS [9] = '{
    "let", "const", "var", "function", "return", "if", "else", "while", "for"
  };

  // One result item as the lexer should deliver it
  typedef struct {
    logic [1:0] kind;
    logic [2:0] ttype;
    logic [7:0] value;
    logic       last;
  } lex_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tlast;

  // Lexer state mirrored by the predictor
  stl_pkg::lex_mode_t scan_mode;
  logic        num_has_dot;
  logic        in_single_quote;
  logic [63:0] word_text;
  int unsigned word_count;
  logic [7:0]  held_op;

  lex_result_t token_results_due [$];
  lex_result_t step_results [$];
  bit          steady_flow;

  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  script_token_lexer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit blank_char(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit digit_char(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit letter_char(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit op_char(logic [7:0] c);
    case (c)
      "+", "-", "*", "/", "(", ")", "=", ";", "{", "}",
      "[", "]", ",", "<", ">", "!", "&", "|": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // True when the held operator and the new byte form a two-character operator
  function automatic bit joins(logic [7:0] first, logic [7:0] second);
    case (second)
      "=": return first == "=" || first == "!" || first == "<" || first == ">";
      "&": return first == "&";
      "|": return first == "|";
      default: return 1'b0;
    endcase
  endfunction

  function automatic void push_result(logic [1:0] kind, logic [2:0] ttype, logic [7:0] value);
    lex_result_t r;
    r.kind  = kind;
    r.ttype = ttype;
    r.value = value;
    r.last  = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void clear_state();
    scan_mode       = stl_pkg::MODE_IDLE;
    num_has_dot     = 1'b0;
    in_single_quote = 1'b0;
    word_text       = '0;
    word_count      = 0;
    held_op         = '0;
  endfunction

  // Keep the first eight bytes; the count saturates one past that
  function automatic void add_word_char(logic [7:0] c);
    if (word_count < 8) word_text = {word_text[55:0], c};
    if (word_count <= 8) word_count++;
  endfunction

  function automatic void close_word();
    logic [2:0] ttype;
    ttype = stl_pkg::TT_IDENT;
    if (word_count <= 8) begin
      foreach (KEYWORD_WORDS[k]) begin
        if (word_text == KEYWORD_WORDS[k]) ttype = stl_pkg::TT_KEYWORD;
      end
    end
    push_result(stl_pkg::KIND_END, ttype, 8'd0);
  endfunction

  function automatic void begin_token(logic [7:0] c);
    scan_mode = stl_pkg::MODE_IDLE;
    if (blank_char(c)) return;
    if (digit_char(c)) begin
      scan_mode   = stl_pkg::MODE_NUMBER;
      num_has_dot = 1'b0;
      push_result(stl_pkg::KIND_VALUE, stl_pkg::TT_NUMBER, c);
    end else if (letter_char(c) || c == "_") begin
      scan_mode  = stl_pkg::MODE_WORD;
      word_text  = '0;
      word_count = 0;
      add_word_char(c);
      push_result(stl_pkg::KIND_VALUE, stl_pkg::TT_IDENT, c);
    end else if (c == "\"" || c == "'") begin
      scan_mode       = stl_pkg::MODE_STRING;
      in_single_quote = (c == "'");
    end else if (c == ".") begin
      push_result(stl_pkg::KIND_VALUE, stl_pkg::TT_DOT, c);
      push_result(stl_pkg::KIND_END, stl_pkg::TT_DOT, 8'd0);
    end else if (op_char(c)) begin
      scan_mode = stl_pkg::MODE_OPERATOR;
      held_op   = c;
      push_result(stl_pkg::KIND_VALUE, stl_pkg::TT_OPERATOR, c);
    end else begin
      // error items carry token type zero
      scan_mode = stl_pkg::MODE_ERROR;
      push_result(stl_pkg::KIND_ERROR, stl_pkg::TT_NUMBER, c);
    end
  endfunction

  // Advance the predictor by one accepted item and queue the results it causes
  function automatic void lex_byte(logic [7:0] c, logic eoi);
    logic [7:0] first;
    step_results.delete();
    if (eoi) begin
      case (scan_mode)
        stl_pkg::MODE_NUMBER:
          push_result(stl_pkg::KIND_END, stl_pkg::TT_NUMBER, 8'd0);
        stl_pkg::MODE_WORD:
          close_word();
        stl_pkg::MODE_STRING, stl_pkg::MODE_ESCAPE:
          push_result(stl_pkg::KIND_END, stl_pkg::TT_STRING, 8'd0);
        stl_pkg::MODE_OPERATOR:
          push_result(stl_pkg::KIND_END, stl_pkg::TT_OPERATOR, 8'd0);
        default: ;
      endcase
      push_result(stl_pkg::KIND_END, stl_pkg::TT_EOF, 8'd0);
      clear_state();
    end else begin
      case (scan_mode)
        stl_pkg::MODE_NUMBER: begin
          if (digit_char(c)) begin
            push_result(stl_pkg::KIND_VALUE, stl_pkg::TT_NUMBER, c);
          end else if (c == "." && !num_has_dot) begin
            num_has_dot = 1'b1;
            push_result(stl_pkg::KIND_VALUE, stl_pkg::TT_NUMBER, c);
          end else begin
            push_result(stl_pkg::KIND_END, stl_pkg::TT_NUMBER, 8'd0);
            begin_token(c);
          end
        end
        stl_pkg::MODE_WORD: begin
          if (letter_char(c) || digit_char(c) || c == "_") begin
            add_word_char(c);
            push_result(stl_pkg::KIND_VALUE, stl_pkg::TT_IDENT, c);
          end else begin
            close_word();
            begin_token(c);
          end
        end
        stl_pkg::MODE_STRING: begin
          if (c == (in_single_quote ? 8'("'") : 8'("\""))) begin
            push_result(stl_pkg::KIND_END, stl_pkg::TT_STRING, 8'd0);
            scan_mode = stl_pkg::MODE_IDLE;
          end else if (c == "\\") begin
            scan_mode = stl_pkg::MODE_ESCAPE;
          end else begin
            push_result(stl_pkg::KIND_VALUE, stl_pkg::TT_STRING, c);
          end
        end
        stl_pkg::MODE_ESCAPE: begin
          case (c)
            "n":     push_result(stl_pkg::KIND_VALUE, stl_pkg::TT_STRING, 8'd10);
            "t":     push_result(stl_pkg::KIND_VALUE, stl_pkg::TT_STRING, 8'd9);
            "r":     push_result(stl_pkg::KIND_VALUE, stl_pkg::TT_STRING, 8'd13);
            default: push_result(stl_pkg::KIND_VALUE, stl_pkg::TT_STRING, c);
          endcase
          scan_mode = stl_pkg::MODE_STRING;
        end
        stl_pkg::MODE_OPERATOR: begin
          first   = held_op;
          held_op = '0;
          if (joins(first, c)) begin
            push_result(stl_pkg::KIND_VALUE, stl_pkg::TT_OPERATOR, c);
            push_result(stl_pkg::KIND_END, stl_pkg::TT_OPERATOR, 8'd0);
            scan_mode = stl_pkg::MODE_IDLE;
          end else begin
            push_result(stl_pkg::KIND_END, stl_pkg::TT_OPERATOR, 8'd0);
            begin_token(c);
          end
        end
        stl_pkg::MODE_ERROR: ;
        default: begin_token(c);
      endcase
    end
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
    foreach (step_results[i]) token_results_due.push_back(step_results[i]);
  endfunction

  // ---------------------------------------------------------------- result check

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    lex_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_checked++;
      if (token_results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tdata %0h tlast %0b",
                 $time, out_tdata, out_tlast);
        mismatch_count++;
      end else begin
        want = token_results_due.pop_front();
        check_field("result_kind", 8'(want.kind), 8'(out_tdata[1:0]));
        check_field("token_type", 8'(want.ttype), 8'(out_tdata[4:2]));
        check_field("value_byte", want.value, out_tdata[12:5]);
        check_field("last_result", 8'(want.last), 8'(out_tlast));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, token_results_due.size());
      $display("** script_token_lexer: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------- idling

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Stall the result channel at random unless a steady stretch is running
  initial begin : drive_ready
    int unsigned stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0 && !steady_flow) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        stall_left = 0;
        if (!steady_flow && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  // Send one item; called and returning at a falling edge
  task automatic send_item(input logic [7:0] c, input logic eoi);
    int unsigned gap;
    gap = (steady_flow || $urandom_range(0, 9) < 6) ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      in_tlast  <= 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= c;
    in_tlast  <= eoi;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    lex_byte(c, eoi);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // End of input with a random byte that the lexer must ignore
  task automatic send_end();
    send_item(8'($urandom), 1'b1);
  endtask

  function automatic logic [7:0] pick_char(string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  // Second dot ends the number and becomes a dot token, then a lone dot
  task automatic test_number_dots();
    send_text("7.5..");
    send_end();
  endtask

  // Raw extreme bytes inside a string, an escape, then a dangling backslash
  task automatic test_string_escapes();
    send_item("'", 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_text("\\n\\");
    send_end();
  endtask

  // Keyword value characters come out typed as identifier; two-character operator after it
  task automatic test_keyword_operator();
    send_text("if<=");
    send_end();
  endtask

  // Invalid bytes: high byte, then ignored input, end of input in the error state; then byte zero
  task automatic test_invalid_bytes();
    send_item(8'hFF, 1'b0);
    send_item("a", 1'b0);
    send_end();
    send_item(8'h00, 1'b0);
    send_end();
  endtask

  task automatic send_number();
    int unsigned n;
    n = $urandom_range(1, 5);
    repeat (n) send_item(pick_char("0123456789"), 1'b0);
    if ($urandom_range(0, 9) < 3) begin
      send_item(".", 1'b0);
      n = $urandom_range(0, 3);
      repeat (n) send_item(pick_char("0123456789"), 1'b0);
      if ($urandom_range(0, 9) == 0) send_item(".", 1'b0);
    end
  endtask

  task automatic send_identifier();
    int unsigned n;
    n = $urandom_range(1, 12);
    send_item(pick_char("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_"), 1'b0);
    repeat (n - 1) send_item(pick_char("abcxyzABCXYZ_0189efilnorstuw"), 1'b0);
  endtask

  // A keyword, sometimes cut short or lengthened into a plain identifier
  task automatic send_keyword();
    logic [63:0] text;
    logic [7:0]  chars [$];
    text = KEYWORD_WORDS[$urandom_range(0, 8)];
    for (int j = 7; j >= 0; j--) begin
      if (text[j*8 +: 8] != 8'd0) chars.push_back(text[j*8 +: 8]);
    end
    if (chars.size() > 1 && $urandom_range(0, 9) < 2) void'(chars.pop_back());
    if ($urandom_range(0, 9) < 3) chars.push_back(pick_char("sx_9"));
    foreach (chars[i]) send_item(chars[i], 1'b0);
  endtask

  task automatic send_string();
    logic [7:0]  quote;
    logic [7:0]  b;
    int unsigned n;
    quote = ($urandom_range(0, 1) == 1) ? 8'("'") : 8'("\"");
    send_item(quote, 1'b0);
    n = $urandom_range(0, 6);
    repeat (n) begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          send_item("\\", 1'b0);
          if ($urandom_range(0, 3) == 0) send_item(8'($urandom), 1'b0);
          else send_item(pick_char("ntr\\\"'x"), 1'b0);
        end
        3, 4: begin
          b = 8'($urandom);
          if (b == quote || b == "\\") b = "x";
          send_item(b, 1'b0);
        end
        default: send_item(pick_char("abc XYZ 019.+=;_\"'"), 1'b0);
      endcase
    end
    // leave some strings open so that an end of input or the next token finds them
    if ($urandom_range(0, 9) < 9) send_item(quote, 1'b0);
  endtask

  task automatic send_operator();
    logic [7:0] first;
    first = pick_char("+-*/()=;{}[],<>!&|");
    send_item(first, 1'b0);
    if ($urandom_range(0, 1) == 1) begin
      if ($urandom_range(0, 1) == 1)
        send_item((first == "&" || first == "|") ? first : 8'("="), 1'b0);
      else
        send_item(pick_char("+-*/()=;{}[],<>!&|"), 1'b0);
    end
  endtask

  // One random program: tokens with random separators, closed by end of input
  task automatic send_program();
    int unsigned tokens;
    tokens = $urandom_range(3, 12);
    steady_flow = ($urandom_range(0, 4) == 0);
    repeat (tokens) begin
      case ($urandom_range(0, 15))
        0, 1:   send_number();
        2, 3:   send_identifier();
        4, 5:   send_keyword();
        6, 7:   send_string();
        8, 9:   send_operator();
        10:     repeat ($urandom_range(1, 3)) send_item(".", 1'b0);
        11, 12: repeat ($urandom_range(1, 3)) send_item(pick_char(" \t\n\r\v\f"), 1'b0);
        13, 14: send_item(pick_char("0a_\"'.=&|<!"), 1'b0);
        default: send_item(8'($urandom), 1'b0);
      endcase
      if ($urandom_range(0, 9) < 7) send_item(pick_char(" \t\n\r\v\f"), 1'b0);
    end
    send_end();
  endtask

  task automatic test_random_programs();
    int unsigned start_count;
    start_count = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS) send_program();
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    in_tlast        = 1'b0;
    steady_flow     = 1'b0;
    items_sent      = 0;
    results_checked = 0;
    mismatch_count  = 0;
    cycle_count     = 0;
    clear_state();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_number_dots();
    test_string_escapes();
    test_keyword_operator();
    test_invalid_bytes();
    test_random_programs();

    // drop valid and drain the remaining results
    in_tvalid <= 1'b0;
    while (token_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d source items, checked %0d results, %0d mismatches.",
             items_sent, results_checked, mismatch_count);
    $display("Covered numbers, words, keywords, strings, dots, operators, bad bytes, stalls.");
    if (mismatch_count == 0) begin
      $display("** script_token_lexer: PASSED **");
    end else begin
      $display("** script_token_lexer: FAILED **");
    end
    $finish;
  end

endmodule
